// ===== rtl/tea_pkg.sv =====
package tea_pkg;

    // fixed-point layout
    localparam int FRAC_BITS = 32;
    localparam int ARG_FRAC  = 16;
    localparam int ARG_W     = 21;
    localparam int MAG_W     = 21;
    localparam int MAX_TERMS = 32;
    localparam int CNT_W     = 6;

    // term magnitude and signed accumulator widths
    localparam int TERM_W = 60;
    localparam int ACC_W  = 66;
    localparam int OUT_W  = 64;

    // split multiply: term halves times magnitude
    localparam int HALF_W = TERM_W / 2;
    localparam int PP_W   = HALF_W + MAG_W;
    localparam int PROD_W = TERM_W + MAG_W;

    // long division by the term index, one byte of dividend a cycle
    localparam int DIGIT_W   = 8;
    localparam int DIV_STEPS = 9;
    localparam int DIV_W     = DIGIT_W * DIV_STEPS;
    localparam int DCNT_W    = 4;

    // reciprocal divider: quotient of 2^(2*FRAC_BITS) by a sum of at least 2^FRAC_BITS
    localparam int QUOT_W = FRAC_BITS + 1;
    localparam int RCNT_W = 6;

    // configuration register indexes
    localparam logic [1:0] CFG_NUM_TERMS = 2'd0;
    localparam logic [1:0] CFG_USE_RECIP = 2'd1;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             neg;
        logic             recip;
        logic [CNT_W-1:0] n;
    } t_cell_ctx;

    typedef struct packed {
        logic [TERM_W-1:0] term;
        logic [ACC_W-1:0]  acc;
        t_cell_ctx         ctx;
    } t_cell_word;

endpackage

// ===== rtl/tea_cell.sv =====
module tea_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [tea_pkg::CNT_W-1:0]     i_index,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  tea_pkg::t_cell_word           i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output tea_pkg::t_cell_word           o_out
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_SUM  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_ACC  = 3'd4;
    localparam logic [2:0] S_HOLD = 3'd5;

    logic [2:0]                    r_phase;
    tea_pkg::t_cell_word           r_word;
    logic [tea_pkg::PP_W-1:0]      r_pl;
    logic [tea_pkg::PP_W-1:0]      r_ph;
    logic [tea_pkg::DIV_W-1:0]     r_div;
    logic [tea_pkg::CNT_W-1:0]     r_rem;
    logic [tea_pkg::DCNT_W-1:0]    r_cnt;

    logic [tea_pkg::PROD_W-1:0]    n_prod;
    logic [tea_pkg::DIGIT_W-1:0]   n_digit;
    logic [tea_pkg::DIGIT_W-1:0]   n_qdig;
    logic [tea_pkg::CNT_W-1:0]     n_rem;
    logic [tea_pkg::ACC_W-1:0]     n_term_ext;
    logic                          n_sub;

    assign o_in_ready  = (r_phase == S_IDLE);
    assign o_out_valid = (r_phase == S_HOLD);
    assign o_out       = r_word;

    // partial products recombined; the scaling down by the argument fraction follows in S_SUM
    assign n_prod = tea_pkg::PROD_W'(r_pl) + (tea_pkg::PROD_W'(r_ph) << tea_pkg::HALF_W);

    // one byte of restoring division by the cell index
    always_comb begin
        n_digit = r_div[tea_pkg::DIV_W-1 -: tea_pkg::DIGIT_W];
        n_rem   = r_rem;
        n_qdig  = '0;
        for (int k = tea_pkg::DIGIT_W - 1; k >= 0; k--) begin
            n_rem = {n_rem[tea_pkg::CNT_W-2:0], n_digit[k]};
            if (n_rem >= i_index) begin
                n_rem     = n_rem - i_index;
                n_qdig[k] = 1'b1;
            end
        end
    end

    // odd terms of a negative argument subtract outside reciprocal mode
    assign n_sub      = r_word.ctx.neg & ~r_word.ctx.recip & i_index[0];
    assign n_term_ext = tea_pkg::ACC_W'(r_div[tea_pkg::TERM_W-1:0]);

    // cell sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= S_IDLE;
        end else begin
            case (r_phase)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_phase <= (i_index > i_in.ctx.n) ? S_HOLD : S_MUL;
                    end
                end
                S_MUL:  r_phase <= S_SUM;
                S_SUM:  r_phase <= S_DIV;
                S_DIV: begin
                    if (r_cnt == tea_pkg::DCNT_W'(tea_pkg::DIV_STEPS - 1)) begin
                        r_phase <= S_ACC;
                    end
                end
                S_ACC:  r_phase <= S_HOLD;
                S_HOLD: begin
                    if (i_out_ready) begin
                        r_phase <= S_IDLE;
                    end
                end
                default: r_phase <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_phase)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_word <= i_in;
                end
            end
            S_MUL: begin
                r_pl <= tea_pkg::PP_W'(r_word.term[tea_pkg::HALF_W-1:0])
                      * tea_pkg::PP_W'(r_word.ctx.mag);
                r_ph <= tea_pkg::PP_W'(r_word.term[tea_pkg::TERM_W-1:tea_pkg::HALF_W])
                      * tea_pkg::PP_W'(r_word.ctx.mag);
            end
            S_SUM: begin
                r_div <= tea_pkg::DIV_W'(n_prod >> tea_pkg::ARG_FRAC);
                r_rem <= '0;
                r_cnt <= '0;
            end
            S_DIV: begin
                r_div <= {r_div[tea_pkg::DIV_W-tea_pkg::DIGIT_W-1:0], n_qdig};
                r_rem <= n_rem;
                r_cnt <= r_cnt + 1'b1;
            end
            S_ACC: begin
                r_word.term <= r_div[tea_pkg::TERM_W-1:0];
                r_word.acc  <= n_sub ? (r_word.acc - n_term_ext)
                                     : (r_word.acc + n_term_ext);
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/tea_recip.sv =====
module tea_recip (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  tea_pkg::t_cell_word           i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [tea_pkg::OUT_W-1:0]     o_exp_value,
    output logic                          o_saturated
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_HOLD = 2'd2;

    logic [1:0]                    r_phase;
    logic [tea_pkg::ACC_W-1:0]     r_den;
    logic [tea_pkg::ACC_W:0]       r_rem;
    logic [tea_pkg::QUOT_W-1:0]    r_quot;
    logic [tea_pkg::RCNT_W-1:0]    r_cnt;
    logic [tea_pkg::OUT_W-1:0]     r_exp;
    logic                          r_sat;

    logic                          n_ge;
    logic [tea_pkg::ACC_W:0]       n_diff;
    logic                          n_fits;
    logic [tea_pkg::OUT_W-1:0]     n_clamp;

    assign o_in_ready  = (r_phase == S_IDLE);
    assign o_out_valid = (r_phase == S_HOLD);
    assign o_exp_value = r_exp;
    assign o_saturated = r_sat;

    // one quotient bit per cycle
    assign n_ge   = (r_rem >= {1'b0, r_den});
    assign n_diff = n_ge ? (r_rem - {1'b0, r_den}) : r_rem;

    // range check of the direct sum against the signed output word
    assign n_fits  = (i_in.acc[tea_pkg::ACC_W-1:tea_pkg::OUT_W-1] == '0)
                   || (i_in.acc[tea_pkg::ACC_W-1:tea_pkg::OUT_W-1] == '1);
    assign n_clamp = i_in.acc[tea_pkg::ACC_W-1] ? {1'b1, {(tea_pkg::OUT_W-1){1'b0}}}
                                                : {1'b0, {(tea_pkg::OUT_W-1){1'b1}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= S_IDLE;
        end else begin
            case (r_phase)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_phase <= i_in.ctx.recip ? S_DIV : S_HOLD;
                    end
                end
                S_DIV: begin
                    if (r_cnt == tea_pkg::RCNT_W'(tea_pkg::QUOT_W - 1)) begin
                        r_phase <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (i_out_ready) begin
                        r_phase <= S_IDLE;
                    end
                end
                default: r_phase <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_phase)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_den  <= i_in.acc;
                    r_rem  <= (tea_pkg::ACC_W + 1)'(1) << tea_pkg::FRAC_BITS;
                    r_quot <= '0;
                    r_cnt  <= '0;
                    r_exp  <= n_fits ? i_in.acc[tea_pkg::OUT_W-1:0] : n_clamp;
                    r_sat  <= ~n_fits;
                end
            end
            S_DIV: begin
                r_quot <= {r_quot[tea_pkg::QUOT_W-2:0], n_ge};
                r_rem  <= n_diff << 1;
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == tea_pkg::RCNT_W'(tea_pkg::QUOT_W - 1)) begin
                    r_exp <= {{(tea_pkg::OUT_W - tea_pkg::QUOT_W){1'b0}},
                              r_quot[tea_pkg::QUOT_W-2:0], n_ge};
                    r_sat <= 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/taylor_exp_approximation.sv =====
// flow: each summed term passes its cell's multiply, sum, byte-serial division and accumulate
// states; each cell past the term count (32 cells) hands the word straight on, and the word
// then leaves direct or through the reciprocal divider; a cell or the divider takes a new word
// only after handing on its last one, and this includes the bit-serial reciprocal divider
// reset: synchronous active-low; num_terms returns to 10, use_reciprocal to 1,
// all cells and the divider empty
module taylor_exp_approximation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [20:0] x_value, [23:21] zero
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [63:0] exp_value
    output logic        o_m_axis_tuser,   // [0] saturated
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [5:0]  i_cfg_wdata
);

    localparam int NC = tea_pkg::MAX_TERMS;
    localparam int CW = tea_pkg::CNT_W;

    logic [CW-1:0] r_num_terms;
    logic          r_use_recip;

    logic [tea_pkg::ARG_W-1:0] n_x;
    logic                      n_neg;
    tea_pkg::t_cell_word       n_first;

    tea_pkg::t_cell_word w_word  [0:NC];
    logic                w_valid [0:NC];
    logic                w_ready [0:NC];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_terms <= CW'(10);
            r_use_recip <= 1'b1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                tea_pkg::CFG_NUM_TERMS: r_num_terms <= i_cfg_wdata;
                tea_pkg::CFG_USE_RECIP: r_use_recip <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // argument magnitude, sign and starting word
    always_comb begin
        n_x                 = i_s_axis_tdata[tea_pkg::ARG_W-1:0];
        n_neg               = n_x[tea_pkg::ARG_W-1];
        n_first.term        = tea_pkg::TERM_W'(1) << tea_pkg::FRAC_BITS;
        n_first.acc         = tea_pkg::ACC_W'(1) << tea_pkg::FRAC_BITS;
        n_first.ctx.mag     = n_neg ? (~n_x + 1'b1) : n_x;
        n_first.ctx.neg     = n_neg;
        n_first.ctx.recip   = r_use_recip & (n_neg | (n_x == '0));
        n_first.ctx.n       = (r_num_terms > CW'(NC)) ? CW'(NC) : r_num_terms;
    end

    assign w_valid[0]      = i_s_axis_tvalid;
    assign w_word[0]       = n_first;
    assign o_s_axis_tready = w_ready[0];

    // row of term cells, cell k forms term k+1
    for (genvar k = 0; k < NC; k++) begin : g_cell
        tea_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_index     (CW'(k + 1)),
            .i_in_valid  (w_valid[k]),
            .o_in_ready  (w_ready[k]),
            .i_in        (w_word[k]),
            .o_out_valid (w_valid[k+1]),
            .i_out_ready (w_ready[k+1]),
            .o_out       (w_word[k+1])
        );
    end

    // reciprocal, range clamp and output register
    tea_recip u_recip (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (w_valid[NC]),
        .o_in_ready  (w_ready[NC]),
        .i_in        (w_word[NC]),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_exp_value (o_m_axis_tdata),
        .o_saturated (o_m_axis_tuser)
    );

endmodule
